/* rtl/tpc_pkg.sv */
// Shared constants and types for the trapezoid profile calculator.
package tpc_pkg;

    localparam int DIV_W      = 48;  // divider datapath width
    localparam int RATE_STEPS = 16;  // quotient bits of the rate scaling chains
    localparam int CNT_STEPS  = 32;  // quotient bits of the step count chains

    localparam logic [15:0] MIN_RATE_RESET = 16'd120;
    localparam logic [15:0] RATE_MAX       = 16'hFFFF;

    // one restoring-division cell worth of data
    typedef struct packed {
        logic [DIV_W:0]   rem;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] den;
    } t_div;

    // values that ride alongside the divider chains
    typedef struct packed {
        logic [31:0] nr2;
        logic [22:0] a2;
        logic [46:0] a2c;
        logic [23:0] count;
        logic [15:0] floor_rate;
        logic        zero_nom;
        logic        ovf_e;
        logic        ovf_x;
        logic [15:0] ir;
        logic [15:0] fr;
        logic        neg_a;
        logic        neg_d;
        logic        neg_i;
        logic        ovf_i;
    } t_side;

endpackage

/* rtl/tpc_if.sv */
// Valid/ready channel interfaces for segment items and profile items.
interface tpc_in_if;
    logic        valid;
    logic        ready;
    logic [27:0] speed_entry;
    logic [27:0] exit_speed;
    logic [27:0] speed_cruise;
    logic [15:0] rate_cruise;
    logic [21:0] accel_steps_per_s2;
    logic [23:0] step_count;

    modport source (
        output valid, speed_entry, exit_speed, speed_cruise, rate_cruise,
               accel_steps_per_s2, step_count,
        input  ready
    );
    modport sink (
        input  valid, speed_entry, exit_speed, speed_cruise, rate_cruise,
               accel_steps_per_s2, step_count,
        output ready
    );
endinterface

interface tpc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] accel_end_step;
    logic [31:0] decel_start_step;
    logic [15:0] rate_start;
    logic [15:0] rate_end;

    modport source (
        output valid, accel_end_step, decel_start_step, rate_start, rate_end,
        input  ready
    );
    modport sink (
        input  valid, accel_end_step, decel_start_step, rate_start, rate_end,
        output ready
    );
endinterface

/* rtl/tpc_div_cell.sv */
// One restoring division step: shifts in a dividend bit, emits one quotient bit.
module tpc_div_cell import tpc_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);

    logic [DIV_W:0] w_trial;
    logic           w_fit;
    t_div           n_d;
    t_div           r_d;

    always_comb begin
        w_trial = {i_d.rem[DIV_W-1:0], i_d.num[DIV_W-1]};
        w_fit   = (w_trial >= {1'b0, i_d.den});
        n_d.rem = w_fit ? (w_trial - {1'b0, i_d.den}) : w_trial;
        n_d.num = {i_d.num[DIV_W-2:0], 1'b0};
        n_d.quo = {i_d.quo[DIV_W-2:0], w_fit};
        n_d.den = i_d.den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

/* rtl/trapezoid_profile_calc.sv */
// Top level: pipelined trapezoid profile calculator built on divider cell chains.
//
//  channel  | dir | handshake    | carries
//  ---------+-----+--------------+---------------------------------------------
//  i_seg    | in  | valid/ready  | speeds, cruise rate, accel, step count
//  o_prof   | out | valid/ready  | accel_end_step, decel_start_step, rates
//  i_cfg_*  | in  | write enable | min_step_rate
//
// One item per cycle sustained while the skid register is empty. The pipeline
// is two divider chains in series: 16 cells for the scaled rates, then 32 cells
// for the step counts, plus seven stages of registers, multipliers and adders.
// Synchronous active-low reset clears all valid bits and loads min_step_rate
// with 120. The whole pipeline advances together while the skid register is
// empty; a stall on o_prof fills the skid and only then drops i_seg.ready.
module trapezoid_profile_calc import tpc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [15:0]   i_cfg_wr_data,
    tpc_in_if.sink        i_seg,
    tpc_out_if.source     o_prof
);

    typedef struct packed {
        logic [31:0] au;
        logic [31:0] da;
        logic [15:0] ir;
        logic [15:0] fr;
    } t_res;

    // rate after saturation and floor
    function automatic logic [15:0] f_rate(input logic zn, input logic ovf,
                                           input logic [15:0] q,
                                           input logic [15:0] fl);
        logic [15:0] s;
        s = ovf ? RATE_MAX : q;
        if (zn) begin
            return fl;
        end
        return (s < fl) ? fl : s;
    endfunction

    function automatic logic [31:0] f_sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -36'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    logic [15:0] r_min_rate;
    logic        en;

    // stage 1: input capture
    logic        r_v1;
    logic [27:0] r_e1, r_x1, r_nom1;
    logic [15:0] r_nrate1, r_fl1;
    logic [21:0] r_acc1;
    logic [23:0] r_cnt1;

    // stage 2: products
    logic        r_v2;
    logic [43:0] r_pe2, r_px2;
    logic [31:0] r_nr2_2;
    logic [46:0] r_a2c2;
    logic [27:0] r_nom2;
    logic [22:0] r_a2_2;
    logic [23:0] r_cnt2;
    logic [15:0] r_fl2;

    logic [44:0] w_ne, w_nx;
    t_side       w_side_r;
    t_div        w_e [RATE_STEPS+1];
    t_div        w_x [RATE_STEPS+1];
    t_side       r_sb_r [RATE_STEPS];
    logic [RATE_STEPS-1:0] r_v_r;

    // stage 3..5
    logic        r_v3, r_v4, r_v5;
    t_side       n_sd3, r_sd3, r_sd4, r_sd5;
    logic [31:0] r_ir2_4, r_fr2_4;
    logic signed [32:0] r_da5, r_dd5;
    logic signed [48:0] r_ni5;

    logic [31:0] w_mag_a, w_mag_d;
    logic [23:0] w_a4;
    t_side       w_side_c;
    t_div        w_a [CNT_STEPS+1];
    t_div        w_d [CNT_STEPS+1];
    t_div        w_i [CNT_STEPS+1];
    t_side       r_sb_c [CNT_STEPS];
    logic [CNT_STEPS-1:0] r_v_c;

    // stage 6: counts and plateau
    t_side              w_sc;
    logic signed [33:0] n_acc6, n_dec6;
    logic [23:0]        n_ai6;
    logic               r_v6;
    logic signed [33:0] r_acc6;
    logic signed [35:0] r_pl6;
    logic [23:0]        r_ai6;
    logic [15:0]        r_ir6, r_fr6;

    // output register and skid
    t_res n_res;
    t_res r_o, r_sk;
    logic r_ov, r_skid_v;

    assign en          = !r_skid_v;
    assign i_seg.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rate <= MIN_RATE_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_rate <= i_cfg_wr_data;
        end
    end

    // valid bits of the whole pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v_r <= '0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v_c <= '0;
            r_v6  <= 1'b0;
        end else if (en) begin
            r_v1  <= i_seg.valid;
            r_v2  <= r_v1;
            r_v_r <= {r_v_r[RATE_STEPS-2:0], r_v2};
            r_v3  <= r_v_r[RATE_STEPS-1];
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v_c <= {r_v_c[CNT_STEPS-2:0], r_v5};
            r_v6  <= r_v_c[CNT_STEPS-1];
        end
    end

    // stages 1 and 2
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1     <= i_seg.speed_entry;
            r_x1     <= i_seg.exit_speed;
            r_nom1   <= i_seg.speed_cruise;
            r_nrate1 <= i_seg.rate_cruise;
            r_acc1   <= i_seg.accel_steps_per_s2;
            r_cnt1   <= i_seg.step_count;
            r_fl1    <= (r_min_rate == 16'd0) ? 16'd1 : r_min_rate;

            r_pe2    <= 44'(r_nrate1) * 44'(r_e1);
            r_px2    <= 44'(r_nrate1) * 44'(r_x1);
            r_nr2_2  <= 32'(r_nrate1) * 32'(r_nrate1);
            r_a2c2   <= 47'({r_acc1, 1'b0}) * 47'(r_cnt1);
            r_nom2   <= r_nom1;
            r_a2_2   <= {r_acc1, 1'b0};
            r_cnt2   <= r_cnt1;
            r_fl2    <= r_fl1;
        end
    end

    // ceiling numerators; quotient fits 16 bits unless the overflow flag is set
    always_comb begin
        w_ne = 45'(r_pe2) + 45'(r_nom2) - 45'd1;
        w_nx = 45'(r_px2) + 45'(r_nom2) - 45'd1;

        w_side_r            = '0;
        w_side_r.nr2        = r_nr2_2;
        w_side_r.a2         = r_a2_2;
        w_side_r.a2c        = r_a2c2;
        w_side_r.count      = r_cnt2;
        w_side_r.floor_rate = r_fl2;
        w_side_r.zero_nom   = (r_nom2 == 28'd0);
        w_side_r.ovf_e      = (w_ne >= {1'b0, r_nom2, 16'd0});
        w_side_r.ovf_x      = (w_nx >= {1'b0, r_nom2, 16'd0});

        w_e[0].rem = (DIV_W+1)'(w_ne >> RATE_STEPS);
        w_e[0].num = {w_ne[RATE_STEPS-1:0], (DIV_W-RATE_STEPS)'(0)};
        w_e[0].quo = '0;
        w_e[0].den = DIV_W'(r_nom2);
        w_x[0].rem = (DIV_W+1)'(w_nx >> RATE_STEPS);
        w_x[0].num = {w_nx[RATE_STEPS-1:0], (DIV_W-RATE_STEPS)'(0)};
        w_x[0].quo = '0;
        w_x[0].den = DIV_W'(r_nom2);
    end

    genvar g;
    generate
        for (g = 0; g < RATE_STEPS; g++) begin : g_rate
            tpc_div_cell u_cell_e (.i_clk(i_clk), .i_en(en), .i_d(w_e[g]), .o_d(w_e[g+1]));
            tpc_div_cell u_cell_x (.i_clk(i_clk), .i_en(en), .i_d(w_x[g]), .o_d(w_x[g+1]));
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb_r[0] <= w_side_r;
            for (int k = 1; k < RATE_STEPS; k++) begin
                r_sb_r[k] <= r_sb_r[k-1];
            end
        end
    end

    // stage 3: final rates
    always_comb begin
        n_sd3    = r_sb_r[RATE_STEPS-1];
        n_sd3.ir = f_rate(n_sd3.zero_nom, n_sd3.ovf_e,
                          w_e[RATE_STEPS].quo[15:0], n_sd3.floor_rate);
        n_sd3.fr = f_rate(n_sd3.zero_nom, n_sd3.ovf_x,
                          w_x[RATE_STEPS].quo[15:0], n_sd3.floor_rate);
    end

    // stages 3 to 5: squares and numerators
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd3   <= n_sd3;
            r_sd4   <= r_sd3;
            r_ir2_4 <= 32'(r_sd3.ir) * 32'(r_sd3.ir);
            r_fr2_4 <= 32'(r_sd3.fr) * 32'(r_sd3.fr);
            r_sd5   <= r_sd4;
            r_da5   <= $signed({1'b0, r_sd4.nr2}) - $signed({1'b0, r_ir2_4});
            r_dd5   <= $signed({1'b0, r_sd4.nr2}) - $signed({1'b0, r_fr2_4});
            r_ni5   <= $signed({2'b0, r_sd4.a2c}) + $signed({17'd0, r_fr2_4})
                       - $signed({17'd0, r_ir2_4});
        end
    end

    // sign-magnitude split for the count dividers
    always_comb begin
        w_mag_a = r_da5[32] ? 32'(-r_da5) : r_da5[31:0];
        w_mag_d = r_dd5[32] ? 32'(-r_dd5) : r_dd5[31:0];
        w_a4    = {r_sd5.a2, 1'b0};

        w_side_c       = r_sd5;
        w_side_c.neg_a = r_da5[32];
        w_side_c.neg_d = r_dd5[32];
        w_side_c.neg_i = r_ni5[48];
        w_side_c.ovf_i = (r_ni5[47:0] >= {w_a4, 24'd0});

        w_a[0].rem = '0;
        w_a[0].num = {w_mag_a, (DIV_W-CNT_STEPS)'(0)};
        w_a[0].quo = '0;
        w_a[0].den = DIV_W'(r_sd5.a2);
        w_d[0].rem = '0;
        w_d[0].num = {w_mag_d, (DIV_W-CNT_STEPS)'(0)};
        w_d[0].quo = '0;
        w_d[0].den = DIV_W'(r_sd5.a2);
        w_i[0].rem = (DIV_W+1)'(r_ni5[47:0] >> CNT_STEPS);
        w_i[0].num = {r_ni5[CNT_STEPS-1:0], (DIV_W-CNT_STEPS)'(0)};
        w_i[0].quo = '0;
        w_i[0].den = DIV_W'(w_a4);
    end

    generate
        for (g = 0; g < CNT_STEPS; g++) begin : g_cnt
            tpc_div_cell u_cell_a (.i_clk(i_clk), .i_en(en), .i_d(w_a[g]), .o_d(w_a[g+1]));
            tpc_div_cell u_cell_d (.i_clk(i_clk), .i_en(en), .i_d(w_d[g]), .o_d(w_d[g+1]));
            tpc_div_cell u_cell_i (.i_clk(i_clk), .i_en(en), .i_d(w_i[g]), .o_d(w_i[g+1]));
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb_c[0] <= w_side_c;
            for (int k = 1; k < CNT_STEPS; k++) begin
                r_sb_c[k] <= r_sb_c[k-1];
            end
        end
    end

    // stage 6: signed counts, plateau and the clamped intersection point
    always_comb begin
        w_sc = r_sb_c[CNT_STEPS-1];
        if (w_sc.a2 == 23'd0) begin
            n_acc6 = '0;
            n_dec6 = '0;
        end else begin
            n_acc6 = w_sc.neg_a ? -$signed({2'b0, w_a[CNT_STEPS].quo[31:0]})
                                :  $signed({2'b0, w_a[CNT_STEPS].quo[31:0]});
            n_dec6 = w_sc.neg_d ? -$signed({2'b0, w_d[CNT_STEPS].quo[31:0]})
                                :  $signed({2'b0, w_d[CNT_STEPS].quo[31:0]});
        end
        priority if (w_sc.neg_i) begin
            n_ai6 = '0;
        end else if (w_sc.ovf_i || (w_i[CNT_STEPS].quo[23:0] > w_sc.count)) begin
            n_ai6 = w_sc.count;
        end else begin
            n_ai6 = w_i[CNT_STEPS].quo[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_acc6 <= n_acc6;
            r_pl6  <= $signed({12'd0, w_sc.count}) - 36'(n_acc6) - 36'(n_dec6);
            r_ai6  <= n_ai6;
            r_ir6  <= w_sc.ir;
            r_fr6  <= w_sc.fr;
        end
    end

    // negative plateau falls back to the intersection point
    always_comb begin
        n_res.ir = r_ir6;
        n_res.fr = r_fr6;
        if (r_pl6[35]) begin
            n_res.au = {8'd0, r_ai6};
            n_res.da = {8'd0, r_ai6};
        end else begin
            n_res.au = f_sat32(36'(r_acc6));
            n_res.da = f_sat32(36'(r_acc6) + r_pl6);
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (en) begin
            if (r_v6) begin
                if (!r_ov || o_prof.ready) begin
                    r_ov <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (o_prof.ready) begin
                r_ov <= 1'b0;
            end
        end else if (o_prof.ready) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_v6) begin
                if (!r_ov || o_prof.ready) begin
                    r_o <= n_res;
                end else begin
                    r_sk <= n_res;
                end
            end
        end else if (o_prof.ready) begin
            r_o <= r_sk;
        end
    end

    assign o_prof.valid            = r_ov;
    assign o_prof.accel_end_step   = r_o.au;
    assign o_prof.decel_start_step = r_o.da;
    assign o_prof.rate_start       = r_o.ir;
    assign o_prof.rate_end         = r_o.fr;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("skid holds an item while the output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !o_prof.ready) |=> r_skid_v)
        else $error("skid item dropped without being taken");

    a_rates_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o.ir != 16'd0) && (r_o.fr != 16'd0))
        else $error("zero step rate on output");

    a_phase_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> ($signed(r_o.au) <= $signed(r_o.da)))
        else $error("deceleration starts before acceleration ends");
`endif

endmodule
